[rtl/core/prp_pkg.sv]
// Shared types and constants of the point rotate and project pipeline.
// No dependencies; used by the top level and the divider.
package prp_pkg;

   localparam int CW  = 32;   // rotated coordinate, Q.8 signed
   localparam int PW  = 48;   // coordinate times Q2.14 factor
   localparam int NW  = 44;   // projection numerator, signed
   localparam int RW  = 46;   // divider dividend and remainder
   localparam int DW  = 33;   // divider divisor
   localparam int QW  = 11;   // quotient bits that can land in frame
   localparam int SW  = 11;   // frame side register width
   localparam int AW  = 20;   // pixel address width

   localparam logic signed [15:0] OFFSET_X = -16'sd603;
   localparam logic signed [15:0] OFFSET_Y = -16'sd285;
   localparam logic signed [NW-1:0] FOCAL  = NW'(1000);
   localparam logic signed [NW-1:0] CENTER = NW'(400);
   localparam logic signed [PW:0] HALF_LSB = (PW+1)'(8192);

   typedef enum logic [2:0] {
      REG_ROT_X   = 3'd0,
      REG_ROT_Y   = 3'd1,
      REG_ROT_Z   = 3'd2,
      REG_SHIFT_X = 3'd3,
      REG_SHIFT_Y = 3'd4,
      REG_SHIFT_Z = 3'd5,
      REG_WIDTH   = 3'd6,
      REG_HEIGHT  = 3'd7
   } reg_index_type;

   // side flags that travel through the divider with each quotient
   typedef struct packed {
      logic neg;   // quotient is to be negated
      logic bad;   // zero depth or quotient too large for any frame
   } div_side_type;

endpackage

[rtl/core/point_rotate_project_plot_top.sv]
// Top level of the point rotate and project pipeline: APB registers,
// rotation stages, projection and pixel addressing. Uses prp_pkg, prp_div.
//
// One point enters per clock unless the pipeline holds; its pixel beat passes through
// ten stages of offset, three rotations (multiply, then sum and round),
// translation and projection numerator, twelve divider stages (the first loads the
// operands, each of the others settles one quotient bit), then the frame check and
// the address multiply. The whole pipeline holds while a result beat waits unread,
// so a point is taken in any cycle in which the output stage is empty or drained.
module point_rotate_project_plot_top #(
   parameter int MAX_SIDE = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // point_x[15:0], point_y[31:16], point_z[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // pixel_address[19:0], zero fill[23:20]
   output logic        rsp_tuser,   // in_frame[0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import prp_pkg::*;

   localparam int NS = 10 + (QW + 1) + 2;

   // ---------------- registers ----------------
   logic [31:0]        rot_x_ff, rot_y_ff, rot_z_ff;
   logic signed [15:0] shift_x_ff, shift_y_ff, shift_z_ff;
   logic [SW-1:0]      width_ff, height_ff;
   logic               wr_in;
   reg_index_type      idx_in;

   assign csr_pready = 1'b1;
   assign wr_in      = csr_psel & csr_penable & csr_pwrite;
   assign idx_in     = reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_x_ff   <= 32'h4000_0000;
         rot_y_ff   <= 32'h4000_0000;
         rot_z_ff   <= 32'h4000_0000;
         shift_x_ff <= '0;
         shift_y_ff <= 16'sd2000;
         shift_z_ff <= '0;
         width_ff   <= SW'(1000);
         height_ff  <= SW'(1000);
      end else if (wr_in) begin
         case (idx_in)
            REG_ROT_X:   rot_x_ff   <= csr_pwdata;
            REG_ROT_Y:   rot_y_ff   <= csr_pwdata;
            REG_ROT_Z:   rot_z_ff   <= csr_pwdata;
            REG_SHIFT_X: shift_x_ff <= csr_pwdata[15:0];
            REG_SHIFT_Y: shift_y_ff <= csr_pwdata[15:0];
            REG_SHIFT_Z: shift_z_ff <= csr_pwdata[15:0];
            REG_WIDTH:   width_ff   <= csr_pwdata[SW-1:0];
            REG_HEIGHT:  height_ff  <= csr_pwdata[SW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx_in)
         REG_ROT_X:   csr_prdata = rot_x_ff;
         REG_ROT_Y:   csr_prdata = rot_y_ff;
         REG_ROT_Z:   csr_prdata = rot_z_ff;
         REG_SHIFT_X: csr_prdata = 32'(unsigned'(shift_x_ff));
         REG_SHIFT_Y: csr_prdata = 32'(unsigned'(shift_y_ff));
         REG_SHIFT_Z: csr_prdata = 32'(unsigned'(shift_z_ff));
         REG_WIDTH:   csr_prdata = 32'(width_ff);
         REG_HEIGHT:  csr_prdata = 32'(height_ff);
         default:     csr_prdata = '0;
      endcase
   end

   // saturate frame sides
   logic [SW-1:0] w_in, h_in;
   assign w_in = (32'(width_ff) > MAX_SIDE)  ? SW'(MAX_SIDE) : width_ff;
   assign h_in = (32'(height_ff) > MAX_SIDE) ? SW'(MAX_SIDE) : height_ff;

   logic signed [15:0] cx, sx, cy, sy, cz, sz;
   assign cx = rot_x_ff[31:16];
   assign sx = rot_x_ff[15:0];
   assign cy = rot_y_ff[31:16];
   assign sy = rot_y_ff[15:0];
   assign cz = rot_z_ff[31:16];
   assign sz = rot_z_ff[15:0];

   // ---------------- flow control ----------------
   logic          adv;
   logic [NS-1:0] v_ff;

   assign adv        = !v_ff[NS-1] || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NS-2:0], req_tvalid};
      end
   end

   // ---------------- offset ----------------
   logic signed [15:0]   px, py, pz;
   logic signed [CW-1:0] x0_ff, y0_ff, z0_ff;
   assign px = req_tdata[15:0];
   assign py = req_tdata[31:16];
   assign pz = req_tdata[47:32];

   always_ff @(posedge clock) begin
      if (adv) begin
         x0_ff <= (CW'(px) + CW'(OFFSET_X)) <<< 8;
         y0_ff <= (CW'(py) + CW'(OFFSET_Y)) <<< 8;
         z0_ff <= CW'(pz) <<< 8;
      end
   end

   // round Q.22 sum to Q.8, ties up
   function automatic logic signed [CW-1:0] rnd14(input logic signed [PW-1:0] a,
                                                 input logic signed [PW-1:0] b);
      logic signed [PW:0] t;
      t = (PW+1)'(a) + (PW+1)'(b) + HALF_LSB;
      return t[CW+13:14];
   endfunction

   // ---------------- rotation about X ----------------
   logic signed [PW-1:0] xa_ff, xb_ff, xc_ff, xd_ff;
   logic signed [CW-1:0] x1p_ff, x1_ff, y1_ff, z1_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         xa_ff  <= PW'(y0_ff) * PW'(cx);
         xb_ff  <= PW'(z0_ff) * PW'(sx);
         xc_ff  <= PW'(z0_ff) * PW'(cx);
         xd_ff  <= -(PW'(y0_ff) * PW'(sx));
         x1p_ff <= x0_ff;
         y1_ff  <= rnd14(xa_ff, xb_ff);
         z1_ff  <= rnd14(xc_ff, xd_ff);
         x1_ff  <= x1p_ff;
      end
   end

   // ---------------- rotation about Y ----------------
   logic signed [PW-1:0] ya_ff, yb_ff, yc_ff, yd_ff;
   logic signed [CW-1:0] y2p_ff, x2_ff, y2_ff, z2_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ya_ff  <= PW'(x1_ff) * PW'(cy);
         yb_ff  <= PW'(z1_ff) * PW'(sy);
         yc_ff  <= PW'(z1_ff) * PW'(cy);
         yd_ff  <= -(PW'(x1_ff) * PW'(sy));
         y2p_ff <= y1_ff;
         x2_ff  <= rnd14(ya_ff, yb_ff);
         z2_ff  <= rnd14(yc_ff, yd_ff);
         y2_ff  <= y2p_ff;
      end
   end

   // ---------------- rotation about Z ----------------
   logic signed [PW-1:0] za_ff, zb_ff, zc_ff, zd_ff;
   logic signed [CW-1:0] z3p_ff, x3_ff, y3_ff, z3_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         za_ff  <= PW'(x2_ff) * PW'(cz);
         zb_ff  <= PW'(y2_ff) * PW'(sz);
         zc_ff  <= PW'(y2_ff) * PW'(cz);
         zd_ff  <= -(PW'(x2_ff) * PW'(sz));
         z3p_ff <= z2_ff;
         x3_ff  <= rnd14(za_ff, zb_ff);
         y3_ff  <= rnd14(zc_ff, zd_ff);
         z3_ff  <= z3p_ff;
      end
   end

   // ---------------- translation and projection numerators ----------------
   logic signed [CW-1:0] xt_ff, yt_ff, zt_ff, yk_ff;
   logic signed [NW-1:0] xf_ff, zf_ff, yc4_ff;
   logic [RW-1:0]        ncol_ff, nrow_ff;
   logic [DW-1:0]        dd_ff;
   div_side_type         scol_ff, srow_ff;

   logic signed [NW-1:0] ncs_in, nrs_in;
   logic [NW-1:0]        ncabs_in, nrabs_in;
   logic [CW-1:0]        dabs_in;

   assign ncs_in   = xf_ff + yc4_ff;
   assign nrs_in   = zf_ff + yc4_ff;
   assign ncabs_in = ncs_in[NW-1] ? NW'(-ncs_in) : NW'(ncs_in);
   assign nrabs_in = nrs_in[NW-1] ? NW'(-nrs_in) : NW'(nrs_in);
   assign dabs_in  = yk_ff[CW-1] ? CW'(-yk_ff) : CW'(yk_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         xt_ff   <= x3_ff + (CW'(shift_x_ff) <<< 8);
         yt_ff   <= y3_ff + (CW'(shift_y_ff) <<< 8);
         zt_ff   <= z3_ff + (CW'(shift_z_ff) <<< 8);
         xf_ff   <= NW'(xt_ff) * FOCAL;
         zf_ff   <= NW'(zt_ff) * FOCAL;
         yc4_ff  <= NW'(yt_ff) * CENTER;
         yk_ff   <= yt_ff;
         // dividend 2|n|+|d|, divisor 2|d|: rounds half away from zero
         ncol_ff <= (RW'(ncabs_in) << 1) + RW'(dabs_in);
         nrow_ff <= (RW'(nrabs_in) << 1) + RW'(dabs_in);
         dd_ff   <= {dabs_in, 1'b0};
         scol_ff <= '{neg: ncs_in[NW-1] ^ yk_ff[CW-1], bad: 1'b0};
         srow_ff <= '{neg: nrs_in[NW-1] ^ yk_ff[CW-1], bad: 1'b0};
      end
   end

   // ---------------- division ----------------
   logic [QW-1:0] qcol, qrow;
   div_side_type  socol, sorow;

   prp_div u_div_col (
      .clock    (clock),
      .en       (adv),
      .num      (ncol_ff),
      .den      (dd_ff),
      .side_in  (scol_ff),
      .quot     (qcol),
      .side_out (socol)
   );

   prp_div u_div_row (
      .clock    (clock),
      .en       (adv),
      .num      (nrow_ff),
      .den      (dd_ff),
      .side_in  (srow_ff),
      .quot     (qrow),
      .side_out (sorow)
   );

   // ---------------- frame check and address ----------------
   logic          inf_in;
   logic          inf_ff, out_inf_ff;
   logic [QW-1:0] col_ff, row_ff;
   logic [SW-1:0] wa_ff;
   logic [AW-1:0] addr_ff;
   logic [QW+SW:0] addr_in;

   // a negative quotient is in frame only when it rounds to zero
   assign inf_in = !socol.bad && !sorow.bad
                && (!socol.neg || qcol == '0) && (!sorow.neg || qrow == '0)
                && (qcol < QW'(w_in)) && (qrow < QW'(h_in));
   assign addr_in = (QW+SW+1)'(row_ff) * (QW+SW+1)'(wa_ff) + (QW+SW+1)'(col_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         inf_ff     <= inf_in;
         col_ff     <= qcol;
         row_ff     <= qrow;
         wa_ff      <= w_in;
         out_inf_ff <= inf_ff;
         addr_ff    <= inf_ff ? addr_in[AW-1:0] : '0;
      end
   end

   assign rsp_tdata = {4'b0, addr_ff};
   assign rsp_tuser = out_inf_ff;

`ifndef SYNTHESIS
   a_first_stage: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v_ff[0])
      else $error("accepted point missing from first stage");
   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      (v_ff[NS-2] && inf_ff) |-> (col_ff < QW'(wa_ff)))
      else $error("in-frame column beyond width");
   a_off_frame_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (addr_ff == '0))
      else $error("out-of-frame beat carries an address");
`endif

endmodule

[rtl/core/prp_div.sv]
// Pipelined restoring divider, one quotient bit per g_step stage.
// Depends on prp_pkg; flags out quotients that do not fit in QW bits.
module prp_div (
   input  logic                   clock,
   input  logic                   en,
   input  logic [prp_pkg::RW-1:0] num,
   input  logic [prp_pkg::DW-1:0] den,
   input  prp_pkg::div_side_type  side_in,
   output logic [prp_pkg::QW-1:0] quot,
   output prp_pkg::div_side_type  side_out
);
   import prp_pkg::*;

   logic [RW-1:0] rem_ff  [0:QW];
   logic [DW-1:0] den_ff  [0:QW];
   logic [QW-1:0] q_ff    [0:QW];
   div_side_type  side_ff [0:QW];

   logic          over_in;
   div_side_type  side0_in;

   assign over_in = num >= RW'({den, {QW{1'b0}}});
   always_comb begin
      side0_in     = side_in;
      side0_in.bad = side_in.bad | over_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= num;
         den_ff[0]  <= den;
         q_ff[0]    <= '0;
         side_ff[0] <= side0_in;
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_step
      localparam int BIT = QW - k;
      logic [RW-1:0] trial_in;
      logic          ge_in;
      assign trial_in = RW'(den_ff[k-1]) << BIT;
      assign ge_in    = rem_ff[k-1] >= trial_in;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge_in ? rem_ff[k-1] - trial_in : rem_ff[k-1];
            den_ff[k]  <= den_ff[k-1];
            q_ff[k]    <= ge_in ? q_ff[k-1] | (QW'(1) << BIT) : q_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign quot     = q_ff[QW];
   assign side_out = side_ff[QW];

endmodule
